[rtl/pfa_pkg.sv]
// Shared types and constants for the partition fit allocator.
// No dependencies; used by every module of the block.
package pfa_pkg;

   localparam int CNT_W       = 12;
   localparam int NUM_PARTS   = 3;
   localparam int OP_W        = 2;
   localparam int SEL_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int CHOSEN_W    = 2;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 40;

   // operation codes
   localparam logic [OP_W-1:0] OP_FIRST = 2'd0;
   localparam logic [OP_W-1:0] OP_WORST = 2'd1;
   localparam logic [OP_W-1:0] OP_BEST  = 2'd2;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd3;

   // capacity reset values, partition one in the low slot
   localparam logic [NUM_PARTS-1:0][CNT_W-1:0] CAP_RESET = {12'd200, 12'd100, 12'd150};

   // controller to datapath commands
   typedef struct packed {
      logic load_req;   // latch the accepted request word
      logic commit;     // apply the request and load the result register
   } pfa_cmd_type;

endpackage

[rtl/pfa_ctrl.sv]
// Controller for the partition fit allocator: request/result handshake FSM.
// Depends on pfa_pkg.
module pfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output pfa_pkg::pfa_cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic can_commit;

   assign can_commit = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (can_commit) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/pfa_datapath.sv]
// Datapath for the partition fit allocator: capacity and free-count
// registers, fit selection, result register. Depends on pfa_pkg.
module pfa_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pfa_pkg::pfa_cmd_type                   cmd,
   input  logic [pfa_pkg::OP_W-1:0]              req_op,
   input  logic [pfa_pkg::CNT_W-1:0]             req_size,
   input  logic [pfa_pkg::SEL_W-1:0]             req_sel,
   input  logic                                  csr_wr,
   input  logic [1:0]                            csr_idx,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic [pfa_pkg::CSR_DATA_W-1:0]        csr_rdata,
   output logic [pfa_pkg::STATUS_W-1:0]          res_status,
   output logic [pfa_pkg::CHOSEN_W-1:0]          res_chosen,
   output logic [pfa_pkg::NUM_PARTS-1:0][pfa_pkg::CNT_W-1:0] res_free
);

   localparam int N = pfa_pkg::NUM_PARTS;
   localparam int W = pfa_pkg::CNT_W;

   logic [N-1:0][W-1:0] cap_ff, cap_in;
   logic [N-1:0][W-1:0] free_ff, free_in;
   logic [pfa_pkg::OP_W-1:0]  op_ff;
   logic [W-1:0]              size_ff;
   logic [pfa_pkg::SEL_W-1:0] sel_ff;
   logic [pfa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [pfa_pkg::CHOSEN_W-1:0] chosen_ff, chosen_in;
   logic [N-1:0][W-1:0]       rfree_ff;

   logic                 found;
   logic [1:0]           pick;
   logic [W-1:0]         best_val;
   logic                 sel_ok;

   // fit search over the three partitions, lowest number wins ties
   always_comb begin
      found    = 1'b0;
      pick     = '0;
      best_val = '0;
      for (int i = 0; i < N; i++) begin
         if (free_ff[i] >= size_ff) begin
            if (!found) begin
               found    = 1'b1;
               pick     = 2'(i);
               best_val = free_ff[i];
            end else if (op_ff == pfa_pkg::OP_WORST && free_ff[i] > best_val) begin
               pick     = 2'(i);
               best_val = free_ff[i];
            end else if (op_ff == pfa_pkg::OP_BEST && free_ff[i] < best_val) begin
               pick     = 2'(i);
               best_val = free_ff[i];
            end
         end
      end
   end

   assign sel_ok = (sel_ff >= 3'd1) && (sel_ff <= 3'(N));

   always_comb begin
      cap_in    = cap_ff;
      free_in   = free_ff;
      status_in = pfa_pkg::ST_NO_SPACE;
      chosen_in = '0;
      if (op_ff == pfa_pkg::OP_FREE) begin
         if (sel_ok) begin
            status_in = pfa_pkg::ST_FREED;
            chosen_in = sel_ff[pfa_pkg::CHOSEN_W-1:0];
         end else begin
            status_in = pfa_pkg::ST_INVALID;
         end
      end else if (found) begin
         status_in = pfa_pkg::ST_ALLOCATED;
         chosen_in = pick + 2'd1;
      end
      if (cmd.commit) begin
         for (int i = 0; i < N; i++) begin
            if (op_ff == pfa_pkg::OP_FREE) begin
               if (sel_ff == 3'(i + 1)) free_in[i] = cap_ff[i];
            end else if (found && pick == 2'(i)) begin
               free_in[i] = free_ff[i] - size_ff;
            end
         end
      end
      // config write, reloads the free count too; the user must write only while idle, the block has no guard for it
      if (csr_wr) begin
         for (int i = 0; i < N; i++) begin
            if (csr_idx == 2'(i)) begin
               cap_in[i]  = csr_wdata[W-1:0];
               free_in[i] = csr_wdata[W-1:0];
            end
         end
      end
   end

   always_comb begin
      csr_rdata = '0;
      for (int i = 0; i < N; i++) begin
         if (csr_idx == 2'(i)) csr_rdata = {{(pfa_pkg::CSR_DATA_W - W){1'b0}}, cap_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= pfa_pkg::CAP_RESET;
         free_ff <= pfa_pkg::CAP_RESET;
      end else begin
         cap_ff  <= cap_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_op;
         size_ff <= req_size;
         sel_ff  <= req_sel;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         chosen_ff <= chosen_in;
         rfree_ff  <= free_in;
      end
   end

   assign res_status = status_ff;
   assign res_chosen = chosen_ff;
   assign res_free   = rfree_ff;

endmodule

[rtl/partition_fit_allocator_core.sv]
// Top level of the partition fit allocator: stream ports, APB config port.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
//
// Usage:
//   Request words come in on req_* (tuser = operation, tdata = size and
//   partition select). Each request gives exactly one result word on
//   rsp_* (tuser = status, tdata = chosen partition and the three free
//   counts after the request).
//   A word accepted into the request latch is executed in the cycle after,
//   and the commit of the execute cycle loads the result register that
//   drives rsp_tvalid. A new word is taken only once the last one has
//   left its execute cycle; req_tready is low during the execute cycle.
//   The result register parts the two sides: a new request is taken while
//   an older result still waits. If the receiver stalls, the next request
//   waits in its execute cycle until the result register is free.
//   Capacity registers sit at csr byte addresses 0, 4 and 8. A write also
//   reloads that partition's free count; write only while idle.
//   Reset: capacities go to 150, 100, 200 and free counts follow; no result
//   is pending.
module partition_fit_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pfa_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [11:0] request_size, [14:12] partition_select
   input  logic [pfa_pkg::OP_W-1:0]          req_tuser,  // [1:0] operation
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pfa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [1:0] chosen_partition, [13:2] free_first,
                                                         // [25:14] free_second, [37:26] free_third
   output logic [pfa_pkg::STATUS_W-1:0]      rsp_tuser,  // [1:0] status
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pfa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pfa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   pfa_pkg::pfa_cmd_type cmd;
   logic                 csr_wr;
   logic [pfa_pkg::CHOSEN_W-1:0] res_chosen;
   logic [pfa_pkg::NUM_PARTS-1:0][pfa_pkg::CNT_W-1:0] res_free;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   pfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pfa_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_op     (req_tuser),
      .req_size   (req_tdata[11:0]),
      .req_sel    (req_tdata[14:12]),
      .csr_wr     (csr_wr),
      .csr_idx    (csr_paddr[3:2]),
      .csr_wdata  (csr_pwdata),
      .csr_rdata  (csr_prdata),
      .res_status (rsp_tuser),
      .res_chosen (res_chosen),
      .res_free   (res_free)
   );

   // pack result word, zero pad to whole bytes
   assign rsp_tdata = {2'b00, res_free[2], res_free[1], res_free[0], res_chosen};

endmodule

[rtl/pfa_checker.sv]
// Port-level checks for partition_fit_allocator_core, bound to the top.
// Depends on pfa_pkg.
module pfa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pfa_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic [pfa_pkg::STATUS_W-1:0]      rsp_tuser
);

   // stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // stalled result word holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // one request in flight: no accept right after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during execute");

   // chosen partition agrees with status
   a_chosen_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pfa_pkg::ST_NO_SPACE || rsp_tuser == pfa_pkg::ST_INVALID)
      |-> rsp_tdata[1:0] == 2'd0)
      else $error("chosen partition set without allocation or free");

   a_chosen_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pfa_pkg::ST_ALLOCATED || rsp_tuser == pfa_pkg::ST_FREED)
      |-> rsp_tdata[1:0] != 2'd0)
      else $error("allocation or free without a chosen partition");

endmodule

bind partition_fit_allocator_core pfa_checker u_pfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
